/* design/itoa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and the digit glyph lookup for the integer to text
// converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int DEF_VALUE_WIDTH = 32;
    localparam int DEF_MAX_DIGITS  = 32;

    localparam logic [7:0] RADIX_RESET = 8'd10;
    localparam logic [7:0] RADIX_MIN   = 8'd2;
    localparam logic [7:0] RADIX_MAX   = 8'd16;
    localparam logic [7:0] RADIX_DEC   = 8'd10;

    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    // register index 0 of the config space
    localparam logic REG_RADIX = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_EMIT,
        ST_TERM
    } t_state;

    // lower-case hex glyphs
    function automatic logic [7:0] glyph(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = 8'h30 + {4'd0, d};
        end else begin
            c = 8'h57 + {4'd0, d};
        end
        return c;
    endfunction

endpackage

/* design/integer_to_ascii_radix_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_unit
// Signed integer to ASCII text in a programmable base (2 to 16), emitted one
// character per word, most significant first, ending with a NUL marked last.
// ----------------------------------------------------------------------------
// One value is converted at a time. The magnitude is divided by the radix
// bit-serially, one quotient bit per cycle, through the restoring divide
// loop. The digits are parked in a small digit RAM (registered read), then
// read back in reverse: for each character the READ state fetches the digit
// and the EMIT state passes its glyph to the output register. A radix
// outside 2..16 yields only the terminator. In base 10 a negative value gets
// a leading '-'; other bases give the magnitude digits unsigned. s_tready is
// high only while the unit is idle; the final character sits in the output
// register and does not hold up the next value beyond that. The radix
// register (reset 10) lives at byte address 0 and should be written only
// while the unit is idle.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_unit #(
    parameter int VALUE_WIDTH = itoa_pkg::DEF_VALUE_WIDTH,
    parameter int MAX_DIGITS  = itoa_pkg::DEF_MAX_DIGITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      s_tdata,   // [VALUE_WIDTH-1:0] value
    // output stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [7:0]                            m_tdata,   // [7:0] character
    output logic                                  m_tlast,   // last (terminator)
    // APB config port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import itoa_pkg::*;

    localparam int BW = $clog2(VALUE_WIDTH);      // divide bit counter
    localparam int AW = $clog2(MAX_DIGITS);       // digit RAM address
    localparam int CW = $clog2(MAX_DIGITS + 1);   // digit count

    localparam logic [BW-1:0] LAST_BIT  = BW'(VALUE_WIDTH - 1);
    localparam logic [CW-1:0] ROOM_FULL = CW'(MAX_DIGITS);
    localparam logic [CW-1:0] ROOM_SIGN = CW'(MAX_DIGITS - 1);

    // ---------------------------------------------------------------- config
    logic [7:0] r_radix;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RADIX) ? {24'd0, r_radix} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_RADIX)) begin
            r_radix <= pwdata[7:0];
        end
    end

    // ---------------------------------------------------------------- state
    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_q,     n_q;      // running quotient / dividend
    logic [3:0]             r_rem,   n_rem;    // partial remainder
    logic [BW-1:0]          r_bit,   n_bit;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_sign,  n_sign;
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_char,  n_out_char;
    logic                   r_out_last,  n_out_last;

    // digit RAM
    logic [3:0]             r_digits [MAX_DIGITS];
    logic [3:0]             r_rd_data;

    logic [VALUE_WIDTH-1:0] in_value;
    logic                   in_neg;
    logic                   radix_ok;
    logic                   accept;
    logic                   out_free;

    // divide step
    logic [4:0]             trial;
    logic [4:0]             diff;
    logic                   ge;
    logic [VALUE_WIDTH-1:0] step_q;
    logic [3:0]             step_rem;
    logic                   digit_done;
    logic [CW-1:0]          room;
    logic                   wr_en;
    logic                   rd_en;

    assign in_value = s_tdata[VALUE_WIDTH-1:0];
    assign in_neg   = in_value[VALUE_WIDTH-1];
    assign radix_ok = (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX);
    assign s_tready = (r_state == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !r_out_valid || m_tready;

    // radix is at most 16 here, so five bits cover it
    assign trial      = {r_rem, r_q[VALUE_WIDTH-1]};
    assign ge         = (trial >= r_radix[4:0]);
    assign diff       = trial - r_radix[4:0];
    assign step_rem   = ge ? diff[3:0] : trial[3:0];
    assign step_q     = {r_q[VALUE_WIDTH-2:0], ge};
    assign digit_done = (r_state == ST_DIV) && (r_bit == LAST_BIT);
    assign room       = r_sign ? ROOM_SIGN : ROOM_FULL;
    assign wr_en      = digit_done && (r_count < room);
    assign rd_en      = (r_state == ST_READ) && (r_count != '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = radix_ok ? ST_DIV : ST_TERM;
                end
            end
            ST_DIV: begin
                if (digit_done && (step_q == '0)) begin
                    n_state = r_sign ? ST_SIGN : ST_READ;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = (r_count == '0) ? ST_TERM : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_READ;
                end
            end
            ST_TERM: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and output word
    always_comb begin
        n_q         = r_q;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_count     = r_count;
        n_sign      = r_sign;
        n_out_valid = r_out_valid && !m_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_q     = in_neg ? (~in_value + 1'b1) : in_value;
                    n_rem   = '0;
                    n_bit   = '0;
                    n_count = '0;
                    n_sign  = in_neg && (r_radix == RADIX_DEC);
                end
            end
            ST_DIV: begin
                n_q   = step_q;
                n_rem = step_rem;
                n_bit = r_bit + 1'b1;
                if (digit_done) begin
                    n_rem = '0;
                    n_bit = '0;
                    if (wr_en) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_MINUS;
                    n_out_last  = 1'b0;
                end
            end
            ST_READ: begin
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = glyph(r_rd_data);
                    n_out_last  = 1'b0;
                end
            end
            ST_TERM: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_NUL;
                    n_out_last  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_q         <= '0;
            r_rem       <= '0;
            r_bit       <= '0;
            r_count     <= '0;
            r_sign      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_q         <= n_q;
            r_rem       <= n_rem;
            r_bit       <= n_bit;
            r_count     <= n_count;
            r_sign      <= n_sign;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // digit RAM: written least significant first, read back in reverse
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_digits[r_count[AW-1:0]] <= step_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_digits[n_count[AW-1:0]];
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_char;
    assign m_tlast  = r_out_last;

endmodule
